FILE: sv/lcts_pkg.sv
// Shared constants for the load-cell tare and scale block.
// No dependencies; used by the channel interfaces and the core.
`default_nettype none

package lcts_pkg;

    // Field widths
    localparam int CODE_W  = 24;
    localparam int SUM_W   = 31;
    localparam int GAIN_W  = 19;
    localparam int ZLO_W   = 18;
    localparam int ZHI_W   = 17;
    localparam int SHOWN_W = 26;
    localparam int DIFF_W  = CODE_W + 1;
    localparam int PROD_W  = DIFF_W + GAIN_W;
    localparam int W_W     = PROD_W - 16;
    localparam int CFG_IDX_W = 2;

    localparam int TARE_SAMPLES_DEF = 100;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ZONE_LOW = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ZONE_HI  = 2'd2;

    // Configuration reset values
    localparam logic signed [GAIN_W-1:0] GAIN_RST     = 19'sd14233;
    localparam logic signed [ZLO_W-1:0]  ZONE_LOW_RST = -18'sd500;
    localparam logic [ZHI_W-1:0]         ZONE_HI_RST  = 17'd200;

    // Rounding of the Q16 product
    localparam logic signed [PROD_W-1:0] ROUND_HALF = 44'sd32768;

    // Weight limits, hundredths of a gram
    localparam logic signed [W_W-1:0] KG_LIMIT = 28'sd100000;
    localparam logic signed [W_W-1:0] OUT_MIN  = -28'sd33554432;
    localparam logic signed [W_W-1:0] OUT_MAX  = 28'sd33554431;

    // Divide by 1000: floor(x * KG_RECIP / 2^KG_SHIFT) for x < 2^27
    localparam int KG_X_W   = 27;
    localparam int KG_RCP_W = 28;
    localparam int KG_SHIFT = 37;
    localparam int KG_Q_W   = KG_X_W + KG_RCP_W - KG_SHIFT;
    localparam logic [KG_X_W-1:0]   KG_BIAS  = 27'd500;
    localparam logic [KG_RCP_W-1:0] KG_RECIP = 28'd137438954;

endpackage : lcts_pkg

`default_nettype wire

FILE: sv/lcts_in_if.sv
// Input channel: one raw converter code per item, valid/ready handshake.
// Depends on lcts_pkg for the code width.
`default_nettype none

interface lcts_in_if;
    logic                         valid;
    logic                         ready;
    logic [lcts_pkg::CODE_W-1:0]  raw_code;

    modport source (output valid, output raw_code, input ready);
    modport sink   (input valid, input raw_code, output ready);
endinterface : lcts_in_if

`default_nettype wire

FILE: sv/lcts_out_if.sv
// Output channel: one weight result per item, valid/ready handshake.
// Depends on lcts_pkg for the value width.
`default_nettype none

interface lcts_out_if;
    logic                                valid;
    logic                                ready;
    logic                                calibrating;
    logic signed [lcts_pkg::SHOWN_W-1:0] shown_value;
    logic                                in_kilograms;
    logic                                zero_forced;
    logic                                saturated;

    modport source (output valid, output calibrating, output shown_value,
                    output in_kilograms, output zero_forced, output saturated,
                    input ready);
    modport sink   (input valid, input calibrating, input shown_value,
                    input in_kilograms, input zero_forced, input saturated,
                    output ready);
endinterface : lcts_out_if

`default_nettype wire

FILE: sv/load_cell_tare_and_scale_core.sv
// Load-cell tare and scale core: four-stage pipeline, one item per cycle unless stalled.
// Depends on lcts_pkg, lcts_in_if and lcts_out_if.
//
// Each raw code has its sign bit flipped to offset binary. The first
// TARE_SAMPLES items after reset are summed and report calibrating with all
// other fields zero; the floor average of that sum becomes the tare in the
// cycle after the last of them is taken. Later items give
// round((code - tare) * gain_q16 / 65536) in hundredths of a gram, forced to
// zero inside the open zero band, shown in hundredths of a kilogram from
// 1000 g up, and saturated to 26 bits otherwise. The block takes one item per
// cycle unless the output stalls; each item goes from the input register
// through gain multiply, rounding, then kilogram divide into the output
// register. Each stage holds only while the one after it is full and
// stalled, so input keeps flowing while the output waits until the pipeline
// fills up. There is no clearing pass after reset.
`default_nettype none

module load_cell_tare_and_scale_core #(
    parameter int TARE_SAMPLES = lcts_pkg::TARE_SAMPLES_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_we,
    input  wire logic [lcts_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [lcts_pkg::GAIN_W-1:0]      i_cfg_data,
    lcts_in_if.sink                               i_in,
    lcts_out_if.source                            o_out
);

    localparam int CNT_W     = $clog2(TARE_SAMPLES + 1);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(TARE_SAMPLES - 1);
    // floor(sum / TARE_SAMPLES) = floor(sum * TARE_RECIP / 2^TARE_SHIFT)
    localparam int TARE_SHIFT = lcts_pkg::SUM_W + $clog2(TARE_SAMPLES);
    localparam logic [63:0] TARE_RECIP_L =
        ((64'd1 << TARE_SHIFT) + 64'(TARE_SAMPLES) - 64'd1) / 64'(TARE_SAMPLES);
    localparam int RCP_W = 32;
    localparam logic [RCP_W-1:0] TARE_RECIP = TARE_RECIP_L[RCP_W-1:0];
    localparam int TPROD_W = lcts_pkg::SUM_W + RCP_W;

    localparam int CW  = lcts_pkg::CODE_W;
    localparam int DW  = lcts_pkg::DIFF_W;
    localparam int GW  = lcts_pkg::GAIN_W;
    localparam int PW  = lcts_pkg::PROD_W;
    localparam int WW  = lcts_pkg::W_W;
    localparam int SW  = lcts_pkg::SHOWN_W;
    localparam int XW  = lcts_pkg::KG_X_W;
    localparam int RW  = lcts_pkg::KG_RCP_W;
    localparam int QW  = lcts_pkg::KG_Q_W;

    // Configuration
    logic signed [GW-1:0]                 r_gain;
    logic signed [lcts_pkg::ZLO_W-1:0]    r_zone_low;
    logic [lcts_pkg::ZHI_W-1:0]           r_zone_hi;

    // Tare state
    logic [lcts_pkg::SUM_W-1:0] r_sum;
    logic [CNT_W-1:0]           r_count;
    logic [CW-1:0]              r_tare;
    logic                       r_done;
    logic                       r_pend;

    // Pipeline registers
    logic                  r_a_valid, r_b_valid, r_c_valid, r_o_valid;
    logic                  r_a_cal, r_b_cal, r_c_cal;
    logic [CW-1:0]         r_a_code;
    logic signed [PW-1:0]  r_b_prod;
    logic signed [WW-1:0]  r_c_w;
    logic [XW-1:0]         r_c_wk;
    logic                  r_o_cal, r_o_kg, r_o_zf, r_o_sat;
    logic signed [SW-1:0]  r_o_shown;

    logic                  load_a, load_b, load_c, load_o, in_acc;
    logic [CW-1:0]         flip_code;
    logic [TPROD_W-1:0]    tare_prod;
    logic signed [DW-1:0]  b_diff;
    logic signed [PW-1:0]  n_b_prod;
    logic signed [PW-1:0]  c_sum;
    logic signed [WW-1:0]  n_c_w;
    logic [XW-1:0]         n_c_wk;
    logic signed [WW-1:0]  zone_lo_x, zone_hi_x;
    logic [XW+RW-1:0]      kg_prod;
    logic                  n_o_cal, n_o_kg, n_o_zf, n_o_sat;
    logic signed [SW-1:0]  n_o_shown;

    // Each stage advances when empty or when the next one advances
    assign load_o = !r_o_valid || o_out.ready;
    assign load_c = !r_c_valid || load_o;
    assign load_b = !r_b_valid || load_c;
    assign load_a = !r_a_valid || load_b;
    assign i_in.ready = load_a;
    assign in_acc = i_in.valid && load_a;

    assign flip_code = {~i_in.raw_code[CW-1], i_in.raw_code[CW-2:0]};
    assign tare_prod = {{RCP_W{1'b0}}, r_sum} * {{lcts_pkg::SUM_W{1'b0}}, TARE_RECIP};

    // Stage B: offset and gain
    assign b_diff   = $signed({1'b0, r_a_code}) - $signed({1'b0, r_tare});
    assign n_b_prod = $signed({{(PW-DW){b_diff[DW-1]}}, b_diff}
                              * {{(PW-GW){r_gain[GW-1]}}, r_gain});

    // Stage C: round to nearest, floor shift by 16
    assign c_sum  = r_b_prod + lcts_pkg::ROUND_HALF;
    assign n_c_w  = c_sum[PW-1:16];
    assign n_c_wk = n_c_w[XW-1:0] + lcts_pkg::KG_BIAS;

    // Stage O: zero band, kilogram divide, saturation
    assign zone_lo_x = {{(WW-lcts_pkg::ZLO_W){r_zone_low[lcts_pkg::ZLO_W-1]}}, r_zone_low};
    assign zone_hi_x = {{(WW-lcts_pkg::ZHI_W){1'b0}}, r_zone_hi};
    assign kg_prod   = {{RW{1'b0}}, r_c_wk} * {{XW{1'b0}}, lcts_pkg::KG_RECIP};

    always_comb begin
        n_o_cal   = r_c_cal;
        n_o_kg    = 1'b0;
        n_o_zf    = 1'b0;
        n_o_sat   = 1'b0;
        n_o_shown = '0;
        if (!r_c_cal) begin
            if ((r_c_w > zone_lo_x) && (r_c_w < zone_hi_x)) begin
                n_o_zf = 1'b1;
            end else if (r_c_w >= lcts_pkg::KG_LIMIT) begin
                n_o_kg    = 1'b1;
                n_o_shown = $signed({{(SW-QW){1'b0}},
                                     kg_prod[lcts_pkg::KG_SHIFT +: QW]});
            end else if (r_c_w < lcts_pkg::OUT_MIN) begin
                n_o_sat   = 1'b1;
                n_o_shown = lcts_pkg::OUT_MIN[SW-1:0];
            end else if (r_c_w > lcts_pkg::OUT_MAX) begin
                n_o_sat   = 1'b1;
                n_o_shown = lcts_pkg::OUT_MAX[SW-1:0];
            end else begin
                n_o_shown = r_c_w[SW-1:0];
            end
        end
    end

    // Configuration writes; unknown indexes drop
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain     <= lcts_pkg::GAIN_RST;
            r_zone_low <= lcts_pkg::ZONE_LOW_RST;
            r_zone_hi  <= lcts_pkg::ZONE_HI_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                lcts_pkg::CFG_GAIN:     r_gain     <= i_cfg_data;
                lcts_pkg::CFG_ZONE_LOW: r_zone_low <= i_cfg_data[lcts_pkg::ZLO_W-1:0];
                lcts_pkg::CFG_ZONE_HI:  r_zone_hi  <= i_cfg_data[lcts_pkg::ZHI_W-1:0];
                default: ;
            endcase
        end
    end

    // Tare accumulation; the average lands in the cycle after the last sample
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum   <= '0;
            r_count <= '0;
            r_tare  <= '0;
            r_done  <= 1'b0;
            r_pend  <= 1'b0;
        end else begin
            if (in_acc && !r_done) begin
                r_sum   <= r_sum + {{(lcts_pkg::SUM_W-CW){1'b0}}, flip_code};
                r_count <= r_count + 1'b1;
                if (r_count == CNT_LAST) begin
                    r_done <= 1'b1;
                    r_pend <= 1'b1;
                end
            end
            if (r_pend) begin
                r_tare <= tare_prod[TARE_SHIFT +: CW];
                r_pend <= 1'b0;
            end
        end
    end

    // Pipeline valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (load_a) r_a_valid <= i_in.valid;
            if (load_b) r_b_valid <= r_a_valid;
            if (load_c) r_c_valid <= r_b_valid;
            if (load_o) r_o_valid <= r_c_valid;
        end
    end

    // Pipeline payload
    always_ff @(posedge i_clk) begin
        if (load_a) begin
            r_a_code <= flip_code;
            r_a_cal  <= !r_done;
        end
        if (load_b) begin
            r_b_prod <= n_b_prod;
            r_b_cal  <= r_a_cal;
        end
        if (load_c) begin
            r_c_w   <= n_c_w;
            r_c_wk  <= n_c_wk;
            r_c_cal <= r_b_cal;
        end
        if (load_o) begin
            r_o_cal   <= n_o_cal;
            r_o_kg    <= n_o_kg;
            r_o_zf    <= n_o_zf;
            r_o_sat   <= n_o_sat;
            r_o_shown <= n_o_shown;
        end
    end

    assign o_out.valid        = r_o_valid;
    assign o_out.calibrating  = r_o_cal;
    assign o_out.shown_value  = r_o_shown;
    assign o_out.in_kilograms = r_o_kg;
    assign o_out.zero_forced  = r_o_zf;
    assign o_out.saturated    = r_o_sat;

endmodule : load_cell_tare_and_scale_core

`default_nettype wire

FILE: tb/load_cell_tare_and_scale_core_tb.sv
// Testbench for load_cell_tare_and_scale_core: calibration, weighing, zero band,
// kilogram range and saturation across several gain and band settings.
// Depends on lcts_pkg, lcts_in_if, lcts_out_if and the core itself.
`default_nettype none

module load_cell_tare_and_scale_core_tb;
    import lcts_pkg::*;

    localparam int TARE_N      = TARE_SAMPLES_DEF;
    localparam int PHASES      = 7;
    localparam int PHASE_ITEMS = 40;
    localparam int LONG_HOLD   = 40;
    localparam int CYCLE_LIMIT = 50000;

    localparam logic [CODE_W-1:0]    SIGN_BIT  = 24'h800000;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    typedef struct packed {
        logic                      calibrating;
        logic signed [SHOWN_W-1:0] shown_value;
        logic                      in_kilograms;
        logic                      zero_forced;
        logic                      saturated;
    } t_weight;

    class weight_scoreboard;
        longint            gain_q16;
        longint            zone_low;
        longint            zone_high;
        logic [SUM_W-1:0]  tare_sum;
        logic [7:0]        tare_count;
        logic [CODE_W-1:0] tare_value;
        bit                tare_done;
        t_weight           expected_weights[$];
        int                errors;

        function new();
            gain_q16   = longint'(GAIN_RST);
            zone_low   = longint'(ZONE_LOW_RST);
            zone_high  = longint'(ZONE_HI_RST);
            tare_sum   = '0;
            tare_count = '0;
            tare_value = '0;
            tare_done  = 1'b0;
            errors     = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [GAIN_W-1:0] data);
            logic signed [GAIN_W-1:0] g;
            logic signed [ZLO_W-1:0]  lo;
            g  = data;
            lo = data[ZLO_W-1:0];
            case (idx)
                CFG_GAIN:     gain_q16 = longint'(g);
                CFG_ZONE_LOW: zone_low = longint'(lo);
                CFG_ZONE_HI:  zone_high = longint'(data[ZHI_W-1:0]);
                default: ;
            endcase
        endfunction

        function t_weight weigh(logic [CODE_W-1:0] raw);
            t_weight           r;
            logic [CODE_W-1:0] code;
            longint            w;
            r    = '0;
            code = raw ^ SIGN_BIT;
            if (!tare_done) begin
                tare_sum   = tare_sum + SUM_W'(code);
                tare_count = tare_count + 8'd1;
                if (tare_count >= TARE_N) begin
                    tare_value = CODE_W'(tare_sum / TARE_N);
                    tare_done  = 1'b1;
                end
                r.calibrating = 1'b1;
                return r;
            end
            // floor shift after adding half: ties round toward plus infinity
            w = ((longint'(code) - longint'(tare_value)) * gain_q16 + 32768) >>> 16;
            if (w > zone_low && w < zone_high) begin
                r.zero_forced = 1'b1;
            end else if (w >= KG_LIMIT) begin
                r.in_kilograms = 1'b1;
                r.shown_value  = SHOWN_W'((w + 500) / 1000);
            end else if (w < OUT_MIN) begin
                r.shown_value = OUT_MIN[SHOWN_W-1:0];
                r.saturated   = 1'b1;
            end else if (w > OUT_MAX) begin
                r.shown_value = OUT_MAX[SHOWN_W-1:0];
                r.saturated   = 1'b1;
            end else begin
                r.shown_value = SHOWN_W'(w);
            end
            return r;
        endfunction

        // Raw code whose weight lands near target under the current tare and gain.
        function logic [CODE_W-1:0] code_for(longint target, int jitter);
            longint c;
            c = longint'(tare_value);
            if (gain_q16 != 0)
                c += target * 65536 / gain_q16;
            c += jitter;
            if (c < 0)
                c = 0;
            else if (c > 24'hFFFFFF)
                c = 24'hFFFFFF;
            return c[CODE_W-1:0] ^ SIGN_BIT;
        endfunction

        function void note_code(logic [CODE_W-1:0] raw);
            expected_weights.push_back(weigh(raw));
        endfunction

        function int pending();
            return expected_weights.size();
        endfunction

        function void report(string field, logic signed [SHOWN_W-1:0] want_v,
                             logic signed [SHOWN_W-1:0] got_v);
            errors++;
            $display("%0t: %s expected %0d actual %0d", $time, field, want_v, got_v);
        endfunction

        function void check_result(t_weight got);
            t_weight want;
            if (expected_weights.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, expected none actual shown_value %0d",
                         $time, got.shown_value);
                return;
            end
            want = expected_weights.pop_front();
            if (got.calibrating !== want.calibrating)
                report("calibrating", SHOWN_W'(want.calibrating),
                       SHOWN_W'(got.calibrating));
            if (got.shown_value !== want.shown_value)
                report("shown_value", want.shown_value, got.shown_value);
            if (got.in_kilograms !== want.in_kilograms)
                report("in_kilograms", SHOWN_W'(want.in_kilograms),
                       SHOWN_W'(got.in_kilograms));
            if (got.zero_forced !== want.zero_forced)
                report("zero_forced", SHOWN_W'(want.zero_forced),
                       SHOWN_W'(got.zero_forced));
            if (got.saturated !== want.saturated)
                report("saturated", SHOWN_W'(want.saturated), SHOWN_W'(got.saturated));
        endfunction
    endclass

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [GAIN_W-1:0]    i_cfg_data;

    lcts_in_if  in_if();
    lcts_out_if out_if();

    weight_scoreboard sb;
    int               idle_pct;
    bit               hold_req;

    load_cell_tare_and_scale_core #(
        .TARE_SAMPLES(TARE_N)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_if),
        .o_out      (out_if)
    );

    always #1 i_clk = ~i_clk;

    task automatic send_code(input logic [CODE_W-1:0] raw);
        if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
            in_if.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        in_if.valid    <= 1'b1;
        in_if.raw_code <= raw;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        sb.note_code(raw);
    endtask

    task automatic drain();
        in_if.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [GAIN_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        sb.set_reg(idx, data);
    endtask

    // Unused upper data bits and the spare index carry noise that must be dropped.
    task automatic load_settings(input longint g, input longint lo, input longint hi);
        logic [GAIN_W-1:0] noise;
        noise = GAIN_W'($urandom);
        put_reg(CFG_SPARE, noise);
        put_reg(CFG_GAIN, g[GAIN_W-1:0]);
        put_reg(CFG_ZONE_LOW, {noise[0], lo[ZLO_W-1:0]});
        put_reg(CFG_ZONE_HI, {noise[2:1], hi[ZHI_W-1:0]});
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [CODE_W-1:0] random_code();
        logic [CODE_W-1:0] any_code;
        int                sel;
        int                j;
        longint            t;
        sel = $urandom_range(0, 99);
        if (sel < 35) begin
            any_code = CODE_W'($urandom);
            return any_code;
        end
        if (sel < 45) begin
            case ($urandom_range(0, 3))
                0:       return 24'h000000;
                1:       return 24'hFFFFFF;
                2:       return 24'h7FFFFF;
                default: return 24'h800000;
            endcase
        end
        if (sel < 60) begin
            j = $urandom_range(0, 4000);
            return sb.code_for(0, j - 2000);
        end
        case ($urandom_range(0, 5))
            0: t = sb.zone_low;
            1: t = sb.zone_high;
            2: t = KG_LIMIT;
            3: t = KG_LIMIT + 500;
            4: t = OUT_MIN;
            default: begin
                t = $urandom_range(0, 400000);
                t -= 200000;
            end
        endcase
        j = $urandom_range(0, 6);
        return sb.code_for(t, j - 3);
    endfunction

    initial begin : result_sink
        t_weight got;
        int      burst;
        int      hold;
        burst = 0;
        hold  = 0;
        out_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (out_if.valid && out_if.ready) begin
                got.calibrating  = out_if.calibrating;
                got.shown_value  = out_if.shown_value;
                got.in_kilograms = out_if.in_kilograms;
                got.zero_forced  = out_if.zero_forced;
                got.saturated    = out_if.saturated;
                sb.check_result(got);
            end
            // long hold lets the pipeline fill and back up into the input
            if (hold != 0) begin
                hold--;
                out_if.ready <= 1'b0;
            end else if (hold_req) begin
                hold_req = 1'b0;
                hold     = LONG_HOLD - 1;
                out_if.ready <= 1'b0;
            end else if (burst != 0) begin
                burst--;
                out_if.ready <= 1'b0;
            end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
                burst = $urandom_range(0, 3);
                out_if.ready <= 1'b0;
            end else begin
                out_if.ready <= 1'b1;
            end
        end
    end

    initial begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("end of test: mismatches");
        $finish;
    end

    initial begin : stimulus
        int                p;
        int                n;
        longint            g;
        longint            lo;
        longint            hi;
        logic [CODE_W-2:0] low_half;
        sb       = new;
        idle_pct = 0;
        hold_req = 1'b0;
        i_rst_n        <= 1'b0;
        i_cfg_we       <= 1'b0;
        i_cfg_index    <= CFG_GAIN;
        i_cfg_data     <= '0;
        in_if.valid    <= 1'b0;
        in_if.raw_code <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        load_settings(GAIN_RST, ZONE_LOW_RST, ZONE_HI_RST);
        idle_pct = 20;

        // Calibration: corner codes, then codes in the lower offset half so the
        // tare sits off center and both kilogram and saturation ranges open up.
        send_code(24'h000000);
        send_code(24'hFFFFFF);
        send_code(24'h7FFFFF);
        send_code(24'h800000);
        for (n = 4; n < TARE_N; n++) begin
            low_half = (CODE_W-1)'($urandom);
            send_code({1'b1, low_half});
        end

        send_code(24'h000000);
        send_code(24'hFFFFFF);
        send_code(24'h7FFFFF);
        send_code(24'h800000);
        send_code(sb.code_for(0, 0));
        send_code(sb.code_for(0, 1));
        send_code(sb.code_for(0, -1));
        send_code(sb.code_for(sb.zone_low, 0));
        send_code(sb.code_for(sb.zone_low, 1));
        send_code(sb.code_for(sb.zone_high, -1));
        send_code(sb.code_for(sb.zone_high, 0));
        send_code(sb.code_for(KG_LIMIT, -1));
        send_code(sb.code_for(KG_LIMIT, 0));
        send_code(sb.code_for(KG_LIMIT, 1));
        send_code(sb.code_for(KG_LIMIT + 500, 0));
        send_code(sb.code_for(-KG_LIMIT, 0));
        send_code(sb.code_for(OUT_MIN, 0));

        for (p = 1; p <= PHASES; p++) begin
            drain();
            case (p)
                1: begin g = 262143;  lo = -100000; hi = 100000; idle_pct = 30; end
                2: begin g = -262144; lo = 0;       hi = 0;      idle_pct = 0;  end
                3: begin g = 32768;   lo = -3;      hi = 3;      idle_pct = 25; end
                4: begin g = 0;  lo = ZONE_LOW_RST; hi = ZONE_HI_RST; idle_pct = 40; end
                5: begin g = -1;      lo = -1;      hi = 1;      idle_pct = 15; end
                default: begin
                    g = $urandom_range(0, 19'h7FFFF);
                    g -= 262144;
                    lo = $urandom_range(0, 100000);
                    lo = -lo;
                    hi = $urandom_range(0, 100000);
                    idle_pct = (p == PHASES) ? 0 : 30;
                end
            endcase
            load_settings(g, lo, hi);
            for (n = 0; n < PHASE_ITEMS; n++) begin
                if (p == 1 && n == 10)
                    hold_req = 1'b1;
                if (p == 3 && n == 20)
                    drain();
                send_code(random_code());
            end
        end

        drain();
        repeat (8) @(posedge i_clk);
        if (sb.errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule : load_cell_tare_and_scale_core_tb

`default_nettype wire
